// ===== src/dss_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the dual stack block.
// No dependencies.
package dss_pkg;

  localparam int unsigned DEPTH_DEFAULT = 128;
  localparam int unsigned WORD_W = 32;

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP  = 2'd1;
  localparam logic [1:0] CMD_PEEK = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]               command;
    logic                     side;
    logic signed [WORD_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] data;
    logic [1:0]               status;
    logic                     lower_empty;
    logic                     upper_empty;
    logic                     store_full;
  } out_word_t;

  typedef struct packed {
    logic       wr;
    logic       rd;
    logic [1:0] status;
    logic       lower_empty;
    logic       upper_empty;
    logic       store_full;
  } op_t;

  localparam int unsigned OP_W = $bits(op_t);

endpackage

// ===== src/dss_front.sv =====
`timescale 1ns / 1ps
// Front end: stack counters, classification and address generation.
// Depends on dss_pkg.
module dss_front #(
  parameter int unsigned DEPTH = dss_pkg::DEPTH_DEFAULT,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  dss_pkg::in_word_t         in_word_i,
  output dss_pkg::op_t              op_o,
  output logic [AW-1:0]             addr_o,
  output logic [dss_pkg::WORD_W-1:0] value_o
);
  import dss_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  logic [CW-1:0] lower_q, lower_d, upper_q, upper_d;
  logic [CW-1:0] count_sel, addr_full;
  logic [CW:0]   sum_now, sum_next;
  logic          full_now;

  always_comb begin
    lower_d   = lower_q;
    upper_d   = upper_q;
    op_o      = '0;
    addr_full = '0;
    sum_now   = {1'b0, lower_q} + {1'b0, upper_q};
    full_now  = (sum_now >= {1'b0, DEPTH_C});
    count_sel = in_word_i.side ? upper_q : lower_q;
    op_o.status = ST_OK;
    case (in_word_i.command)
      CMD_PUSH: begin
        if (full_now) begin
          op_o.status = ST_FULL;
        end else if (!in_word_i.side) begin
          op_o.wr   = 1'b1;
          addr_full = lower_q;
          lower_d   = lower_q + ONE_C;
        end else begin
          op_o.wr   = 1'b1;
          addr_full = DEPTH_C - ONE_C - upper_q;
          upper_d   = upper_q + ONE_C;
        end
      end
      CMD_POP, CMD_PEEK: begin
        if (count_sel == '0) begin
          op_o.status = ST_EMPTY;
        end else begin
          op_o.rd   = 1'b1;
          addr_full = in_word_i.side ? (DEPTH_C - upper_q) : (lower_q - ONE_C);
          if (in_word_i.command == CMD_POP) begin
            if (in_word_i.side) begin
              upper_d = upper_q - ONE_C;
            end else begin
              lower_d = lower_q - ONE_C;
            end
          end
        end
      end
      default: begin
      end
    endcase
    sum_next         = {1'b0, lower_d} + {1'b0, upper_d};
    op_o.lower_empty = (lower_d == '0);
    op_o.upper_empty = (upper_d == '0);
    op_o.store_full  = (sum_next >= {1'b0, DEPTH_C});
  end

  assign addr_o  = addr_full[AW-1:0];
  assign value_o = in_word_i.value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= '0;
      upper_q <= '0;
    end else if (accept_i) begin
      lower_q <= lower_d;
      upper_q <= upper_d;
    end
  end

endmodule

// ===== src/dss_queue.sv =====
`timescale 1ns / 1ps
// Two-entry queue between front and back ends.
// Does not depend on dss_pkg; its width comes from the caller.
module dss_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] ent_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;

  assign full_o     = (count_q == 2'd2);
  assign valid_o    = (count_q != 2'd0);
  assign pop_data_o = ent_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

// ===== src/dss_back.sv =====
`timescale 1ns / 1ps
// Back end: shared word memory, read stage and output register.
// Depends on dss_pkg.
module dss_back #(
  parameter int unsigned DEPTH = dss_pkg::DEPTH_DEFAULT,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  output logic                       q_pop_o,
  input  dss_pkg::op_t               op_i,
  input  logic [AW-1:0]              addr_i,
  input  logic [dss_pkg::WORD_W-1:0] value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output dss_pkg::out_word_t         out_word_o
);
  import dss_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_q;
  logic              s1_valid_q;
  op_t               s1_op_q;
  logic              out_valid_q;
  out_word_t         out_word_q;
  logic              move, issue;

  assign move    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign issue   = q_valid_i && (!s1_valid_q || move);
  assign q_pop_o = issue;

  always_ff @(posedge clk_i) begin
    if (issue && op_i.wr) begin
      mem[addr_i] <= value_i;
    end
    if (issue && op_i.rd) begin
      rd_q <= mem[addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_op_q <= op_i;
    end
    if (move) begin
      out_word_q.data        <= s1_op_q.rd ? rd_q : '0;
      out_word_q.status      <= s1_op_q.status;
      out_word_q.lower_empty <= s1_op_q.lower_empty;
      out_word_q.upper_empty <= s1_op_q.upper_empty;
      out_word_q.store_full  <= s1_op_q.store_full;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (issue) begin
        s1_valid_q <= 1'b1;
      end else if (move) begin
        s1_valid_q <= 1'b0;
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ===== src/dual_stack_shared_memory.sv =====
`timescale 1ns / 1ps
// Two stacks in one word memory; lower grows up, upper grows down.
// An accepted word passes through the queue, the read stage and the output register.
// One word per cycle while out_stall_i stays low; the single memory port serves one op per cycle.
// Reset clears both stack counts, the queue and the output stage.
// The word memory is not cleared; only written entries are ever read.
module dual_stack_shared_memory #(
  parameter int unsigned DEPTH = dss_pkg::DEPTH_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dss_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dss_pkg::out_word_t out_word_o
);
  import dss_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned QW = OP_W + AW + WORD_W;

  logic              accept, q_full, q_valid, q_pop;
  op_t               f_op, b_op;
  logic [AW-1:0]     f_addr, b_addr;
  logic [WORD_W-1:0] f_value, b_value;
  logic [QW-1:0]     q_in, q_out;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  dss_front #(.DEPTH(DEPTH), .AW(AW)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_word_i(in_word_i),
    .op_o     (f_op),
    .addr_o   (f_addr),
    .value_o  (f_value)
  );

  assign q_in = {f_op, f_addr, f_value};

  dss_queue #(.WIDTH(QW)) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .push_data_i(q_in),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .pop_i      (q_pop),
    .pop_data_o (q_out)
  );

  assign {b_op, b_addr, b_value} = q_out;

  dss_back #(.DEPTH(DEPTH), .AW(AW)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_pop_o    (q_pop),
    .op_i       (b_op),
    .addr_i     (b_addr),
    .value_i    (b_value),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

endmodule
